// ===== rtl/sbph_pkg.sv =====
// ----------------------------------------------------------------------------
// sbph_pkg
// shared types, codes and constants of the spectrum bar peak-hold unit
// ----------------------------------------------------------------------------
`default_nettype none

package sbph_pkg;

  // default sizes handed to the top level parameters
  localparam int NUM_BINS_DEF   = 32;
  localparam int MAX_HEIGHT_DEF = 319;

  // stream payload layout
  localparam int BIN_W       = 5;
  localparam int PART_W      = 16;
  localparam int OUT_H_W     = 9;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 40;  // 5 + 16 + 16 = 37, padded to bytes
  localparam int OUT_TDATA_W = 24;  // 5 + 9 + 9 = 23, padded to bytes

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_BIN   = 2'd1;
  localparam logic [OP_W-1:0] OP_FRAME = 2'd2;

  // configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES = 2'd2;

  localparam int PERIOD_W = 16;
  localparam int HOLD_W   = 4;
  localparam logic [PERIOD_W-1:0] BAR_PERIOD_RST  = 16'd60;
  localparam logic [PERIOD_W-1:0] PEAK_PERIOD_RST = 16'd100;
  localparam logic [HOLD_W-1:0]   HOLD_FRAMES_RST = 4'd10;

  // square root of 4*(re^2+im^2): 34-bit radicand, 17 result bits
  localparam int RAD_W       = 34;
  localparam int ROOT_W      = 17;
  localparam int REM_W       = 18;
  localparam int SQRT_STEPS  = 17;
  localparam int STEP_CNT_W  = 5;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the input item
    logic tick;      // count one sample tick
    logic fe_start;  // count a tick and decide the decay flags
    logic mul;       // square both parts
    logic sq_load;   // load the root unit
    logic sq_step;   // one root digit
    logic rd_bin;    // read the addressed bin
    logic rd_walk;   // read the walked bin
    logic wr_upd;    // write back the updated bin and load the result
    logic wr_walk;   // write back the decayed bin
  } sbph_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            bin_ok;
    logic            out_free;
  } sbph_sts_t;

endpackage

`default_nettype wire

// ===== rtl/sbph_ram.sv =====
// ----------------------------------------------------------------------------
// sbph_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sbph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/sbph_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbph_ctrl
// sequencer for bin updates and the frame-end walk over all bins
// ----------------------------------------------------------------------------
`default_nettype none

module sbph_ctrl #(
  parameter int NUM_BINS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  sbph_pkg::sbph_sts_t         sts,
  output sbph_pkg::sbph_cmd_t         cmd,
  output logic [$clog2(NUM_BINS)-1:0] walk_idx
);

  import sbph_pkg::*;

  localparam int BW = $clog2(NUM_BINS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_FE_RD = 3'd6;
  localparam logic [2:0] S_FE_WR = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [STEP_CNT_W-1:0] step_r, step_nxt;
  logic [BW-1:0]         walk_r, walk_nxt;
  logic                  acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign walk_idx  = walk_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    walk_nxt  = walk_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.capture = 1'b1;
          case (sts.op)
            OP_TICK: cmd.tick = 1'b1;
            OP_FRAME: begin
              cmd.fe_start = 1'b1;
              walk_nxt     = '0;
              state_nxt    = S_FE_RD;
            end
            OP_BIN: begin
              if (sts.bin_ok) begin
                state_nxt = S_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.sq_load = 1'b1;
        step_nxt    = STEP_CNT_W'(SQRT_STEPS - 1);
        state_nxt   = S_SQRT;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        step_nxt    = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_bin = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        if (sts.out_free) begin
          cmd.wr_upd = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FE_RD: begin
        cmd.rd_walk = 1'b1;
        state_nxt   = S_FE_WR;
      end
      S_FE_WR: begin
        cmd.wr_walk = 1'b1;
        walk_nxt    = walk_r + 1'b1;
        if (walk_r == BW'(NUM_BINS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FE_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      walk_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      walk_r  <= walk_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sbph_dp.sv =====
// ----------------------------------------------------------------------------
// sbph_dp
// datapath: squares, digit-serial root, bin state ram, counters, result
// ----------------------------------------------------------------------------
`default_nettype none

module sbph_dp #(
  parameter int NUM_BINS   = 32,
  parameter int MAX_HEIGHT = 319
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sbph_pkg::sbph_cmd_t                  cmd,
  input  logic [$clog2(NUM_BINS)-1:0]          walk_idx,
  output sbph_pkg::sbph_sts_t                  sts,
  input  logic [sbph_pkg::OP_W-1:0]            in_tuser,
  input  logic [sbph_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 cfg_valid,
  input  logic [sbph_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sbph_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sbph_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  import sbph_pkg::*;

  localparam int BW = $clog2(NUM_BINS);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int EW = 2 * HW + HOLD_W;
  localparam logic [HW-1:0] MAXH = HW'(MAX_HEIGHT);
  localparam logic [HW:0]   MODV = (HW + 1)'(MAX_HEIGHT + 1);

  // configuration
  logic [PERIOD_W-1:0] bar_period_r, peak_period_r;
  logic [HOLD_W-1:0]   hold_frames_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_period_r  <= BAR_PERIOD_RST;
      peak_period_r <= PEAK_PERIOD_RST;
      hold_frames_r <= HOLD_FRAMES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BAR_PERIOD:  bar_period_r  <= cfg_data;
        CFG_PEAK_PERIOD: peak_period_r <= cfg_data;
        CFG_HOLD_FRAMES: hold_frames_r <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // input decode
  logic [BIN_W-1:0] in_bin;
  assign in_bin     = in_tdata[BIN_W-1:0];
  assign sts.op     = in_tuser;
  assign sts.bin_ok = (32'(in_bin) < NUM_BINS);

  logic [BIN_W-1:0]         bin_r;
  logic signed [PART_W-1:0] re_r, im_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bin_r <= in_bin;
      re_r  <= in_tdata[BIN_W +: PART_W];
      im_r  <= in_tdata[BIN_W + PART_W +: PART_W];
    end
  end

  logic [BW+BIN_W-1:0] bin_ext;
  logic [BW-1:0]       bin_addr;
  assign bin_ext  = {{BW{1'b0}}, bin_r};
  assign bin_addr = bin_ext[BW-1:0];

  // tick counters
  logic [PERIOD_W-1:0] bar_cnt_r, peak_cnt_r, bar_cnt_inc, peak_cnt_inc;
  logic                bar_dec_r, peak_dec_r, bar_hit, peak_hit;

  assign bar_cnt_inc  = (bar_cnt_r == '1) ? bar_cnt_r : bar_cnt_r + 1'b1;
  assign peak_cnt_inc = (peak_cnt_r == '1) ? peak_cnt_r : peak_cnt_r + 1'b1;
  assign bar_hit      = bar_cnt_inc > bar_period_r;
  assign peak_hit     = peak_cnt_inc > peak_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_cnt_r  <= '0;
      peak_cnt_r <= '0;
      bar_dec_r  <= 1'b0;
      peak_dec_r <= 1'b0;
    end else if (cmd.tick) begin
      bar_cnt_r  <= bar_cnt_inc;
      peak_cnt_r <= peak_cnt_inc;
    end else if (cmd.fe_start) begin
      bar_cnt_r  <= bar_hit ? '0 : bar_cnt_inc;
      peak_cnt_r <= peak_hit ? '0 : peak_cnt_inc;
      bar_dec_r  <= bar_hit;
      peak_dec_r <= peak_hit;
    end
  end

  // squares, one multiplier per part
  logic signed [2*PART_W-1:0] re_sq, im_sq;
  logic [2*PART_W-2:0]        re_sq_r, im_sq_r;
  assign re_sq = re_r * re_r;
  assign im_sq = im_r * im_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      re_sq_r <= re_sq[2*PART_W-2:0];
      im_sq_r <= im_sq[2*PART_W-2:0];
    end
  end

  // digit-serial root, one result bit per step, msb first; the level is
  // the root modulo MAX_HEIGHT+1, folded in as the bits arrive
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [HW-1:0]     mod_r;
  logic [2*PART_W-1:0] sq_sum;
  logic [REM_W+1:0]  trial, tcmp, diff;
  logic              ge;
  logic [HW:0]       mod2, mod2_sub;

  assign sq_sum   = {1'b0, re_sq_r} + {1'b0, im_sq_r};
  assign trial    = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign tcmp     = {1'b0, root_r, 2'b01};
  assign ge       = trial >= tcmp;
  assign diff     = trial - tcmp;
  assign mod2     = {mod_r, ge};
  assign mod2_sub = mod2 - MODV;

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      rad_r  <= {sq_sum, 2'b00};
      rem_r  <= '0;
      root_r <= '0;
      mod_r  <= '0;
    end else if (cmd.sq_step) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
      mod_r  <= (mod2 >= MODV) ? mod2_sub[HW-1:0] : mod2[HW-1:0];
    end
  end

  // bin state ram, entries read as zero until first written
  logic                 rd_en, wr_en;
  logic [BW-1:0]        rd_addr, wr_addr;
  logic [EW-1:0]        rd_data, wr_data;
  logic [NUM_BINS-1:0]  vld_r;
  logic                 rd_vld_r;

  assign rd_en   = cmd.rd_bin || cmd.rd_walk;
  assign rd_addr = cmd.rd_walk ? walk_idx : bin_addr;
  assign wr_en   = cmd.wr_upd || cmd.wr_walk;
  assign wr_addr = cmd.wr_walk ? walk_idx : bin_addr;

  sbph_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  logic [HW-1:0]     bar_cur, peak_cur, bar_up, bar_u, peak_u;
  logic [HW-1:0]     bar_w, peak_w;
  logic [HOLD_W-1:0] hold_cur, hold_u, hold_w;

  assign bar_cur  = rd_vld_r ? rd_data[HW-1:0] : '0;
  assign peak_cur = rd_vld_r ? rd_data[HW +: HW] : '0;
  assign hold_cur = rd_vld_r ? rd_data[2*HW +: HOLD_W] : '0;

  // bin update
  always_comb begin
    bar_up = (mod_r > bar_cur) ? mod_r : bar_cur;
    bar_u  = bar_up;
    peak_u = peak_cur;
    hold_u = hold_cur;
    if (bar_up >= peak_cur) begin
      peak_u = bar_up;
      hold_u = hold_frames_r;
      if (bar_up >= MAXH) begin
        bar_u  = MAXH;
        peak_u = MAXH;
      end
    end
  end

  // frame-end decay
  assign bar_w  = (bar_dec_r && bar_cur != '0) ? bar_cur - 1'b1 : bar_cur;
  assign peak_w = (peak_dec_r && peak_cur != '0 && hold_cur == '0) ?
                  peak_cur - 1'b1 : peak_cur;
  assign hold_w = (hold_cur != '0) ? hold_cur - 1'b1 : hold_cur;

  assign wr_data = cmd.wr_walk ? {hold_w, peak_w, bar_w} : {hold_u, peak_u, bar_u};

  // result register
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [HW+OUT_H_W-1:0]  bar_ext, peak_ext;

  assign bar_ext  = {{OUT_H_W{1'b0}}, bar_u};
  assign peak_ext = {{OUT_H_W{1'b0}}, peak_u};
  assign sts.out_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.wr_upd) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_upd) begin
      out_data_r <= {1'b0, peak_ext[OUT_H_W-1:0], bar_ext[OUT_H_W-1:0], bin_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/spectrum_bar_peak_hold_unit.sv =====
// ----------------------------------------------------------------------------
// spectrum_bar_peak_hold_unit
// per-bin bar and peak-cap meter with hold timers and timed decay
// ----------------------------------------------------------------------------
// A bin update item carries one complex spectrum value; the unit forms the
// level floor(2*sqrt(re^2+im^2)) modulo MAX_HEIGHT+1, raises the bin's bar and
// peak cap and returns one result item with the bin's new heights. Sample
// tick items only advance the two decay counters. A frame end item counts a
// tick, then walks every bin through the state ram, reading each bin and then
// writing it back decayed, and holds in_tready low until the walk is done. A
// bin update runs from the accept through the squares, the root unit load,
// 17 digit steps of the root, then one ram read and one write before the next
// accept. The result item sits in an output register, so the unit goes on
// while the result waits, stalling only if a second result is ready before
// the first is taken. Out-of-range bins and the unused operation code are
// dropped at the accept with no result. The bin state ram is not cleared: a
// valid bit per bin makes a never-written bin read as zero, so no clearing
// pass follows reset. Configuration writes are taken every cycle and should
// only be issued while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_bar_peak_hold_unit #(
  parameter int NUM_BINS   = sbph_pkg::NUM_BINS_DEF,
  parameter int MAX_HEIGHT = sbph_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sbph_pkg::IN_TDATA_W-1:0]  in_tdata,   // bin_index, real_part, imag_part
  input  logic [sbph_pkg::OP_W-1:0]        in_tuser,   // operation
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sbph_pkg::OUT_TDATA_W-1:0] out_tdata,  // result_bin, bar_height, peak_height
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sbph_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbph_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import sbph_pkg::*;

  localparam int BW = $clog2(NUM_BINS);

  sbph_cmd_t     cmd;
  sbph_sts_t     sts;
  logic [BW-1:0] walk_idx;

  // registers are always writable
  assign cfg_ready = 1'b1;

  // sequencer: accept decode, root step count, frame-end bin walk
  sbph_ctrl #(
    .NUM_BINS (NUM_BINS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .walk_idx  (walk_idx)
  );

  // datapath: counters, root unit, bin state and result register
  sbph_dp #(
    .NUM_BINS   (NUM_BINS),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .walk_idx   (walk_idx),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

`ifndef ASSERT_OFF
  // an in-range bin update keeps the unit busy for the root
  a_bin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == OP_BIN && in_tdata[BIN_W-1:0] < NUM_BINS |=> !in_tready)
    else $error("bin update accepted without going busy");

  // a frame end always starts the bin walk
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == OP_FRAME |=> !in_tready)
    else $error("frame end accepted without starting the walk");

  // right after an update the peak cap is never below the bar
  a_peak_ge_bar: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (MAX_HEIGHT >= 512) || (out_tdata[22:14] >= out_tdata[13:5]))
    else $error("peak cap below bar in a result");

  // a result never appears right after an idle cycle with no bin work
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a bin update in flight");
`endif

endmodule

`default_nettype wire
